// ===== design/mbc_pkg.sv =====
// shared types and constants for the microphone block conditioner
`timescale 1ns / 1ps
package mbc_pkg;
   localparam int HP_COEF = 32440;
   localparam int LP_KEEP = 22938;
   localparam int LP_TAKE = 9830;
   localparam int QUIET_RMS = 33;
   localparam logic [23:0] GAIN_CAP = 24'hFFFFFF;

   localparam logic [2:0] REG_GAIN_MIN = 3'd0;
   localparam logic [2:0] REG_GAIN_MAX = 3'd1;
   localparam logic [2:0] REG_GAIN_START = 3'd2;
   localparam logic [2:0] REG_TARGET = 3'd3;
   localparam logic [2:0] REG_ADAPT = 3'd4;

   typedef struct packed {
      logic signed [15:0] raw_sample;
      logic block_end;
      logic clear_filters;
   } req_type;

   typedef struct packed {
      logic signed [15:0] clean_sample;
      logic run_last;
      logic [15:0] block_peak;
      logic [15:0] block_rms;
      logic [23:0] gain_used;
      logic [31:0] block_number;
   } rsp_type;

   // queue entry from front to back: sample, clear and close flags
   typedef struct packed {
      logic signed [15:0] sample;
      logic clear;
      logic close;
   } cmd_type;

   // tenths to q8.16: floor((t*65536+5)/10), saturated to 24 bits from 2560 tenths up
   function automatic logic [23:0] tenths_to_q16(input logic [11:0] t);
      logic [31:0] num;
      logic [31:0] q;
      begin
         num = {4'd0, t, 16'd0} + 32'd5;
         q = 32'(({32'd0, num} * 64'd3435973837) >> 35);
         tenths_to_q16 = (q > {8'd0, GAIN_CAP}) ? GAIN_CAP : q[23:0];
      end
   endfunction
endpackage

// ===== design/mbc_stream_if.sv =====
// valid/ready channel carrying one payload
`timescale 1ns / 1ps
interface mbc_stream_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/mbc_front.sv =====
// front end: accepts samples, counts block fill, pushes commands into a small queue
`timescale 1ns / 1ps
module mbc_front import mbc_pkg::*; #(
   parameter int BLOCK_SAMPLES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_payload,
   output logic cmd_valid,
   input  logic cmd_ready,
   output cmd_type cmd_data
);
   localparam int CW = $clog2(BLOCK_SAMPLES + 1);
   logic [CW-1:0] fill_ff, fill_in;
   cmd_type q_ff [2];
   logic [1:0] cnt_ff;
   logic wp_ff, rp_ff;
   logic push, pop;
   logic close;

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd_data = q_ff[rp_ff];
   assign close = req_payload.block_end || (fill_ff + CW'(1) >= CW'(BLOCK_SAMPLES));
   assign fill_in = close ? '0 : fill_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         if (push) begin
            fill_ff <= fill_in;
            wp_ff <= ~wp_ff;
         end
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) q_ff[wp_ff] <= '{req_payload.raw_sample, req_payload.clear_filters, close};
   end
endmodule

// ===== design/mbc_sqrt.sv =====
// iterative floor square root, one result bit per cycle
`timescale 1ns / 1ps
module mbc_sqrt (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] value,
   output logic busy,
   output logic [15:0] root
);
   logic [31:0] rem_ff;
   logic [31:0] r_ff;
   logic [31:0] bit_ff;
   logic [4:0] n_ff;
   logic [33:0] trial;

   assign trial = {2'd0, r_ff} + {2'd0, bit_ff};
   assign root = r_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy <= 1'b0;
      end else if (start) begin
         busy <= 1'b1;
         rem_ff <= value;
         r_ff <= '0;
         bit_ff <= 32'h4000_0000;
         n_ff <= 5'd16;
      end else if (busy) begin
         if ({2'd0, rem_ff} >= trial) begin
            rem_ff <= rem_ff - trial[31:0];
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         n_ff <= n_ff - 5'd1;
         if (n_ff == 5'd1) busy <= 1'b0;
      end
   end
endmodule

// ===== design/mbc_divider.sv =====
// iterative unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mbc_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [47:0] dividend,
   input  logic [31:0] divisor,
   output logic busy,
   output logic [47:0] quotient
);
   logic [47:0] q_ff;
   logic [32:0] rem_ff;
   logic [31:0] d_ff;
   logic [5:0] n_ff;
   logic [32:0] shifted;

   assign shifted = {rem_ff[31:0], q_ff[47]};
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy <= 1'b0;
      end else if (start) begin
         busy <= 1'b1;
         q_ff <= dividend;
         rem_ff <= '0;
         d_ff <= divisor;
         n_ff <= 6'd48;
      end else if (busy) begin
         if (shifted >= {1'b0, d_ff}) begin
            rem_ff <= shifted - {1'b0, d_ff};
            q_ff <= {q_ff[46:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            q_ff <= {q_ff[46:0], 1'b0};
         end
         n_ff <= n_ff - 6'd1;
         if (n_ff == 6'd1) busy <= 1'b0;
      end
   end
endmodule

// ===== design/mbc_back.sv =====
// back end: block store, mean removal, filters, gain, rms and gain adaptation
`timescale 1ns / 1ps
module mbc_back import mbc_pkg::*; #(
   parameter int BLOCK_SAMPLES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_ready,
   input  cmd_type cmd_data,
   input  logic [11:0] gain_min,
   input  logic [11:0] gain_max,
   input  logic [11:0] gain_start,
   input  logic [9:0] target_rms,
   input  logic [6:0] adapt_rate,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data
);
   localparam int AW = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
   localparam int CW = $clog2(BLOCK_SAMPLES + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_MEAN_DIV, ST_MEAN_WAIT,
      ST_RD, ST_HP_A, ST_HP_B, ST_LP_A, ST_LP_B, ST_LP_C, ST_GAIN, ST_SQ,
      ST_MS_DIV, ST_MS_WAIT, ST_SQRT, ST_SQRT_WAIT,
      ST_OUT_RD, ST_OUT_WAIT, ST_OUT,
      ST_AD_DIV, ST_AD_WAIT, ST_AD_MUL, ST_AD_QUO, ST_AD_CLAMP
   } state_type;

   state_type state_ff;
   logic signed [15:0] store [BLOCK_SAMPLES];
   logic signed [15:0] rd_ff;
   logic signed [15:0] vstore [BLOCK_SAMPLES];
   logic signed [15:0] vrd_ff;
   logic [AW-1:0] addr_ff;
   logic [CW-1:0] n_ff, fill_ff, idx_ff;
   logic signed [22:0] sum_ff;
   logic [37:0] sumsq_ff;
   logic [15:0] peak_ff, rms_ff;
   logic signed [31:0] hp_in_ff, hp_out_ff, lp_ff;
   logic [23:0] gain_ff, gain_blk_ff;
   logic [31:0] blocks_ff;
   logic signed [16:0] mean_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic signed [31:0] x_ff, hp_ff;
   logic signed [15:0] v_ff;
   logic [15:0] mag_ff;
   logic signed [40:0] delta_ff;
   logic neg_ff;
   logic [31:0] quo_ff;
   // divider and root units
   logic div_start, div_busy, sq_start, sq_busy;
   logic [47:0] div_num, div_q;
   logic [31:0] div_den;
   logic [15:0] root;
   logic out_fire;

   mbc_divider u_div (.clock, .reset, .start(div_start), .dividend(div_num),
      .divisor(div_den), .busy(div_busy), .quotient(div_q));
   mbc_sqrt u_sqrt (.clock, .reset, .start(sq_start), .value(div_q[31:0]),
      .busy(sq_busy), .root(root));

   function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
      if (a > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (a < -64'sd2147483648) return 32'sh80000000;
      return a[31:0];
   endfunction

   assign cmd_ready = (state_ff == ST_IDLE);
   assign out_fire = rsp_valid && rsp_ready;

   always_comb begin
      div_start = 1'b0;
      div_num = '0;
      div_den = {{(32-CW){1'b0}}, n_ff};
      sq_start = 1'b0;
      unique case (state_ff)
         ST_MEAN_DIV: begin
            div_start = 1'b1;
            div_num = 48'(sum_ff < 0 ? -sum_ff : sum_ff);
         end
         ST_MS_DIV: begin
            div_start = 1'b1;
            div_num = 48'(sumsq_ff);
         end
         ST_SQRT: sq_start = 1'b1;
         ST_AD_DIV: begin
            div_start = 1'b1;
            div_num = {7'd0, target_rms, 31'd0};
            div_den = 32'({16'd0, rms_ff} * 32'd1000);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      logic signed [63:0] t;
      logic signed [63:0] g;
      logic signed [63:0] gmn, gmx;
      logic [63:0] qp;
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         hp_in_ff <= '0;
         hp_out_ff <= '0;
         lp_ff <= '0;
         gain_ff <= tenths_to_q16(12'd10);
         blocks_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (cmd_valid) begin
               if (cmd_data.clear) begin
                  hp_in_ff <= '0;
                  hp_out_ff <= '0;
                  lp_ff <= '0;
                  gain_ff <= tenths_to_q16(gain_start);
               end
               store[fill_ff[AW-1:0]] <= cmd_data.sample;
               if (fill_ff == '0) sum_ff <= 23'(cmd_data.sample);
               else sum_ff <= sum_ff + 23'(cmd_data.sample);
               if (cmd_data.close) begin
                  n_ff <= fill_ff + CW'(1);
                  fill_ff <= '0;
                  state_ff <= ST_MEAN_DIV;
               end else begin
                  fill_ff <= fill_ff + CW'(1);
               end
            end
            ST_MEAN_DIV: state_ff <= ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (!div_busy) begin
               mean_ff <= (sum_ff < 0) ? -17'(div_q[16:0]) : 17'(div_q[16:0]);
               idx_ff <= '0;
               addr_ff <= '0;
               peak_ff <= '0;
               sumsq_ff <= '0;
               gain_blk_ff <= gain_ff;
               state_ff <= ST_RD;
            end
            ST_RD: begin
               rd_ff <= store[addr_ff];
               state_ff <= ST_HP_A;
            end
            ST_HP_A: begin
               x_ff <= 32'((34'(rd_ff) - 34'(mean_ff)) <<< 15);
               state_ff <= ST_HP_B;
            end
            ST_HP_B: begin
               t = 64'(HP_COEF) * (64'(hp_out_ff) + 64'(x_ff) - 64'(hp_in_ff));
               hp_ff <= sat32(t >>> 15);
               hp_in_ff <= x_ff;
               state_ff <= ST_LP_A;
            end
            ST_LP_A: begin
               hp_out_ff <= hp_ff;
               acc_ff <= 64'(LP_KEEP) * 64'(lp_ff);
               state_ff <= ST_LP_B;
            end
            ST_LP_B: begin
               acc_ff <= acc_ff + 64'(LP_TAKE) * 64'(hp_ff);
               state_ff <= ST_LP_C;
            end
            ST_LP_C: begin
               lp_ff <= sat32(acc_ff >>> 15);
               prod_ff <= 64'(sat32(acc_ff >>> 15)) * $signed({40'd0, gain_blk_ff});
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               t = prod_ff < 0 ? -prod_ff : prod_ff;
               t = t >>> 31;
               if (prod_ff < 0) t = -t;
               if (t > 64'sd32767) t = 64'sd32767;
               if (t < -64'sd32768) t = -64'sd32768;
               v_ff <= t[15:0];
               mag_ff <= t < 0 ? 16'(-t) : t[15:0];
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               vstore[addr_ff] <= v_ff;
               if (mag_ff > peak_ff) peak_ff <= mag_ff;
               sumsq_ff <= sumsq_ff + 38'(mag_ff * mag_ff);
               addr_ff <= addr_ff + AW'(1);
               if (idx_ff + CW'(1) == n_ff) begin
                  state_ff <= ST_MS_DIV;
               end else begin
                  state_ff <= ST_RD;
               end
               idx_ff <= idx_ff + CW'(1);
            end
            ST_MS_DIV: state_ff <= ST_MS_WAIT;
            ST_MS_WAIT: if (!div_busy) state_ff <= ST_SQRT;
            ST_SQRT: state_ff <= ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (!sq_busy) begin
               rms_ff <= root;
               blocks_ff <= blocks_ff + 32'd1;
               idx_ff <= '0;
               addr_ff <= '0;
               state_ff <= ST_OUT_RD;
            end
            ST_OUT_RD: begin
               vrd_ff <= vstore[addr_ff];
               state_ff <= ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
               rsp_valid <= 1'b1;
               rsp_data <= '{vrd_ff, idx_ff + CW'(1) == n_ff, peak_ff, rms_ff,
                  gain_blk_ff, blocks_ff};
               state_ff <= ST_OUT;
            end
            ST_OUT: if (out_fire) begin
               rsp_valid <= 1'b0;
               addr_ff <= addr_ff + AW'(1);
               idx_ff <= idx_ff + CW'(1);
               if (idx_ff + CW'(1) == n_ff) begin
                  state_ff <= (rms_ff < 16'(QUIET_RMS)) ? ST_IDLE : ST_AD_DIV;
               end else begin
                  state_ff <= ST_OUT_RD;
               end
            end
            ST_AD_DIV: state_ff <= ST_AD_WAIT;
            ST_AD_WAIT: if (!div_busy) state_ff <= ST_AD_MUL;
            ST_AD_MUL: begin
               t = $signed({16'd0, div_q}) - 64'sd65536;
               delta_ff <= 41'($signed({1'b0, adapt_rate}) * t);
               neg_ff <= t < 0;
               state_ff <= ST_AD_QUO;
            end
            // magnitude / 100 as (magnitude >> 2) / 25 by reciprocal multiply
            ST_AD_QUO: begin
               t = 64'(neg_ff ? -delta_ff : delta_ff);
               qp = {32'd0, t[33:2]} * {33'd0, 31'd1374389535};
               quo_ff <= 32'(qp >> 35);
               state_ff <= ST_AD_CLAMP;
            end
            ST_AD_CLAMP: begin
               t = neg_ff ? -$signed({32'd0, quo_ff}) : $signed({32'd0, quo_ff});
               g = $signed({40'd0, gain_ff}) + t;
               gmn = $signed({40'd0, tenths_to_q16(gain_min)});
               gmx = $signed({40'd0, tenths_to_q16(gain_max)});
               if (g < gmn) g = gmn;
               else if (g > gmx) g = gmx;
               if (g < 0) g = 0;
               if (g > $signed({40'd0, GAIN_CAP})) g = $signed({40'd0, GAIN_CAP});
               gain_ff <= g[23:0];
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ===== design/mic_block_conditioner_agc.sv =====
// top level of the microphone block conditioner with agc
//
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    raw_sample, block_end, clear_filters
// rsp      out  rsp_valid/rsp_ready    clean_sample, run_last, block_peak, block_rms,
//                                      gain_used, block_number
// csr      in   csr_write_enable       csr_index, csr_write_data
//
// an open sample is stored and the back end stays idle; a closing sample starts a block pass
// through the mean divider, the filter and gain steps for each sample, mean square
// division and root, result transfer with sink stalls, and gain adaptation unless the
// block rms is below the quiet level
// synchronous reset clears counters and filter states and sets gain to 1.0; the sample store needs none
// the two-entry queue takes up to two samples while the back end works through a block
`timescale 1ns / 1ps
module mic_block_conditioner_agc import mbc_pkg::*; #(
   parameter int BLOCK_SAMPLES = 64
) (
   input  logic clock,
   input  logic reset,
   mbc_stream_if.sink req,
   mbc_stream_if.source rsp,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [11:0] csr_write_data
);
   logic [11:0] gmin_ff, gmax_ff, gstart_ff;
   logic [9:0] target_ff;
   logic [6:0] adapt_ff;
   logic cmd_valid, cmd_ready;
   cmd_type cmd_data;

   // register file, values masked to their widths
   always_ff @(posedge clock) begin
      if (reset) begin
         gmin_ff <= 12'd5;
         gmax_ff <= 12'd200;
         gstart_ff <= 12'd10;
         target_ff <= 10'd100;
         adapt_ff <= 7'd5;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_GAIN_MIN: gmin_ff <= csr_write_data;
            REG_GAIN_MAX: gmax_ff <= csr_write_data;
            REG_GAIN_START: gstart_ff <= csr_write_data;
            REG_TARGET: target_ff <= csr_write_data[9:0];
            REG_ADAPT: adapt_ff <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // front: accept and mark closing samples
   mbc_front #(.BLOCK_SAMPLES(BLOCK_SAMPLES)) u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_payload(req.payload),
      .cmd_valid, .cmd_ready, .cmd_data);

   // back: block processing and result transfer
   mbc_back #(.BLOCK_SAMPLES(BLOCK_SAMPLES)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .gain_min(gmin_ff), .gain_max(gmax_ff), .gain_start(gstart_ff),
      .target_rms(target_ff), .adapt_rate(adapt_ff),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.payload));
endmodule

// ===== design/mbc_checker.sv =====
// port-level checks for the microphone block conditioner
`timescale 1ns / 1ps
module mbc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last,
   input logic [15:0] rsp_peak,
   input logic [15:0] rsp_rms,
   input logic [31:0] rsp_num
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_rms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rms <= rsp_peak) else $error("rms above peak");
   a_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |-> $stable(rsp_num))
      else $error("block number changed in block");
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid |-> $stable(rsp_peak))
      else $error("peak changed in block");
endmodule

bind mic_block_conditioner_agc mbc_checker u_chk (.clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(rsp.payload.run_last),
   .rsp_peak(rsp.payload.block_peak), .rsp_rms(rsp.payload.block_rms),
   .rsp_num(rsp.payload.block_number));

// ===== verif/tb.sv =====
// testbench for the microphone block conditioner: predicts results and checks every transfer
`timescale 1ns / 1ps

class block_scoreboard;
   mbc_pkg::rsp_type pending_results[$];
   int errors;

   // predictor state and configuration
   logic [11:0] gain_min_t, gain_max_t, gain_start_t;
   logic [9:0] target_milli;
   logic [6:0] adapt_rate;
   logic signed [15:0] store[64];
   int unsigned fill;
   longint hp_in, hp_out, lp_out;
   longint unsigned gain_q16;
   logic [31:0] blocks;

   function void clear_all();
      gain_min_t = 5; gain_max_t = 200; gain_start_t = 10;
      target_milli = 100; adapt_rate = 5;
      fill = 0; hp_in = 0; hp_out = 0; lp_out = 0;
      gain_q16 = to_q16(gain_start_t);
      blocks = 0; errors = 0;
   endfunction

   function longint unsigned to_q16(logic [11:0] t);
      longint unsigned g;
      g = (longint'(t) * 65536 + 5) / 10;
      return (g > 64'hFFFFFF) ? 64'hFFFFFF : g;
   endfunction

   function longint sat32(longint a);
      if (a > 64'sd2147483647) return 64'sd2147483647;
      if (a < -64'sd2147483648) return -64'sd2147483648;
      return a;
   endfunction

   function void write_reg(logic [2:0] idx, logic [11:0] val);
      case (idx)
         mbc_pkg::REG_GAIN_MIN: gain_min_t = val;
         mbc_pkg::REG_GAIN_MAX: gain_max_t = val;
         mbc_pkg::REG_GAIN_START: gain_start_t = val;
         mbc_pkg::REG_TARGET: target_milli = val[9:0];
         mbc_pkg::REG_ADAPT: adapt_rate = val[6:0];
         default: ;
      endcase
   endfunction

   function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function void note_sample(mbc_pkg::req_type it);
      int n;
      longint sum, mean, c, x, hp, lp, prod, mag, ratio, delta, g, gmin, gmax;
      longint unsigned sumsq, a, peak, rms;
      int v[64];
      mbc_pkg::rsp_type r;
      if (it.clear_filters) begin
         hp_in = 0; hp_out = 0; lp_out = 0;
         gain_q16 = to_q16(gain_start_t);
      end
      if (fill >= 64) fill = 0;
      store[fill] = it.raw_sample;
      fill++;
      if (!it.block_end && fill < 64) return;
      n = fill;
      fill = 0;
      sum = 0;
      for (int i = 0; i < n; i++) sum += store[i];
      mean = sum / n;
      peak = 0; sumsq = 0;
      for (int i = 0; i < n; i++) begin
         c = longint'(store[i]) - mean;
         x = sat32(c * 32768);
         hp = sat32((longint'(32440) * (hp_out + x - hp_in)) >>> 15);
         hp_in = x; hp_out = hp;
         lp = sat32((longint'(22938) * lp_out + longint'(9830) * hp) >>> 15);
         lp_out = lp;
         prod = lp * longint'(gain_q16);
         mag = prod < 0 ? -prod : prod;
         mag = mag >> 31;
         if (prod < 0) mag = -mag;
         if (mag > 32767) mag = 32767;
         if (mag < -32768) mag = -32768;
         v[i] = int'(mag);
         a = v[i] < 0 ? -v[i] : v[i];
         if (a > peak) peak = a;
         sumsq += a * a;
      end
      rms = root_floor(sumsq / n);
      blocks++;
      for (int i = 0; i < n; i++) begin
         r.clean_sample = v[i][15:0];
         r.run_last = (i + 1 == n);
         r.block_peak = peak[15:0];
         r.block_rms = rms[15:0];
         r.gain_used = gain_q16[23:0];
         r.block_number = blocks;
         pending_results.push_back(r);
      end
      if (rms >= 33) begin
         ratio = longint'((longint'(target_milli) << 31) / (1000 * rms));
         delta = longint'(adapt_rate) * (ratio - 65536) / 100;
         g = longint'(gain_q16) + delta;
         gmin = to_q16(gain_min_t);
         gmax = to_q16(gain_max_t);
         if (g < gmin) g = gmin;
         else if (g > gmax) g = gmax;
         if (g < 0) g = 0;
         if (g > 64'hFFFFFF) g = 64'hFFFFFF;
         gain_q16 = g;
      end
   endfunction

   function void check_result(mbc_pkg::rsp_type got);
      mbc_pkg::rsp_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected result transfer");
         errors++;
         return;
      end
      want = pending_results.pop_front();
      if (got.clean_sample !== want.clean_sample) begin
         $error("clean_sample expected %0d got %0d", want.clean_sample, got.clean_sample);
         errors++;
      end
      if (got.run_last !== want.run_last) begin
         $error("run_last expected %0d got %0d", want.run_last, got.run_last);
         errors++;
      end
      if (got.block_peak !== want.block_peak) begin
         $error("block_peak expected %0d got %0d", want.block_peak, got.block_peak);
         errors++;
      end
      if (got.block_rms !== want.block_rms) begin
         $error("block_rms expected %0d got %0d", want.block_rms, got.block_rms);
         errors++;
      end
      if (got.gain_used !== want.gain_used) begin
         $error("gain_used expected %0h got %0h", want.gain_used, got.gain_used);
         errors++;
      end
      if (got.block_number !== want.block_number) begin
         $error("block_number expected %0d got %0d", want.block_number, got.block_number);
         errors++;
      end
   endfunction
endclass

module tb;
   import mbc_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = REG_GAIN_MIN;
   logic [11:0] csr_write_data = '0;

   mbc_stream_if #(.payload_type(req_type)) req_ch ();
   mbc_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   block_scoreboard sb;
   bit calm_phase = 1'b0;     // no idling near the end
   bit hold_sink = 1'b0;      // long receiver hold-off
   longint cycle_count = 0;

   mic_block_conditioner_agc u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL mic_block_conditioner_agc");
         $finish;
      end
   end

   // result side: sample on the edge, then pick ready for the next cycle
   initial begin
      int gap;
      gap = 0;
      sb = new();
      sb.clear_all();
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
         if (reset || hold_sink) begin
            rsp_ch.ready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   task hold_results(int cycles);
      hold_sink = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_sink = 1'b0;
   endtask

   // one transfer on the input channel, with random idle bursts ahead of it
   task send_sample(logic signed [15:0] s, logic last, logic clr);
      req_type it;
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      it.raw_sample = s;
      it.block_end = last;
      it.clear_filters = clr;
      req_ch.valid <= 1'b1;
      req_ch.payload <= it;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_sample(it);
   endtask

   task idle_input();
      req_ch.valid <= 1'b0;
   endtask

   // block must be quiet before a register write
   task drain();
      idle_input();
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // one write cycle, then the enable is dropped and the scoreboard updated
   task write_csr(logic [2:0] idx, logic [11:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   function logic signed [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return -16'sh8000;
         2: return 16'(int'($urandom_range(0, 200)) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   // one block of the given length with random content and, if allowed, random clears
   task send_block(int len, bit allow_clear);
      for (int i = 0; i < len; i++)
         send_sample(rand_sample(), (i == len - 1),
                     allow_clear && ($urandom_range(0, 15) == 0));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, single-sample block, clear mid block, quiet block
      send_sample(16'sh7FFF, 1'b0, 1'b1);
      send_sample(-16'sh8000, 1'b0, 1'b0);
      send_sample(16'sh7FFF, 1'b0, 1'b0);
      send_sample(-16'sh8000, 1'b1, 1'b0);
      send_sample(16'sh1234, 1'b1, 1'b0);
      send_sample(16'sd0, 1'b0, 1'b0);
      send_sample(16'sd5, 1'b0, 1'b1);
      send_sample(-16'sd3, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++)
         send_sample((i % 2) ? 16'sh7FFF : -16'sh8000, (i == 7), 1'b0);
      drain();

      // crossed limits and the largest values
      write_csr(REG_GAIN_MIN, 12'hFFF);
      write_csr(REG_GAIN_MAX, 12'd1);
      write_csr(REG_GAIN_START, 12'hFFF);
      write_csr(REG_TARGET, 12'hFFF);
      write_csr(REG_ADAPT, 12'hFFF);
      send_block(5, 1'b0);
      send_block(3, 1'b1);
      drain();

      // full store closes without block_end, receiver held back meanwhile
      write_csr(REG_GAIN_MIN, 12'd1);
      write_csr(REG_GAIN_MAX, 12'd2550);
      write_csr(REG_GAIN_START, 12'd1);
      write_csr(REG_TARGET, 12'd1000);
      write_csr(REG_ADAPT, 12'd100);
      fork
         hold_results(3000);
         for (int i = 0; i < 70; i++) send_sample(rand_sample(), 1'b0, 1'b0);
      join
      send_sample(16'sd1, 1'b1, 1'b0);
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(REG_GAIN_MIN, 12'($urandom_range(1, 40)));
         write_csr(REG_GAIN_MAX, 12'($urandom_range(20, 2550)));
         write_csr(REG_GAIN_START, 12'($urandom_range(1, 300)));
         write_csr(REG_TARGET, 12'($urandom_range(1, 1000)));
         write_csr(REG_ADAPT, (ph == 0) ? 12'd0 : 12'($urandom_range(0, 100)));
         if (ph == 3) calm_phase = 1'b1;
         for (int b = 0; b < 5; b++) begin
            send_block(($urandom_range(0, 9) == 0) ? $urandom_range(30, 64)
                                                    : $urandom_range(1, 8), 1'b1);
         end
         drain();
      end

      idle_input();
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS mic_block_conditioner_agc");
      else
         $display("FAIL mic_block_conditioner_agc");
      $finish;
   end
endmodule
